/* hdl/cle_pkg.sv */
// shared types and constants for the cursor line editor
// no dependencies; imported by every module of the block
`default_nettype none

package cle_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_KEY   = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // input transaction taken, launch memory reads
    logic finish;   // apply the edit and load the output register
  } cle_cmd_t;

endpackage

`default_nettype wire

/* hdl/cursor_line_editor.sv */
// top level of the cursor line editor: controller plus datapath
// depends on cle_pkg, cle_ctrl, cle_datapath
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in_     | input     | in_valid / in_stall | action, key, index
//   out_    | output    | out_valid/out_stall | read_char, text_length, cursor_position,
//           |           |                     | dropped
//
// each transaction: the accept cycle launches the registered reads of both stack
// memories, then the finish state (ST_FIN) applies the edit and loads the output register.
// one transaction is in flight at a time; in_stall is high while it is.
// a stalled result holds the finish state until the output register frees up.
// reset clears the stack counts, the controller state and out_valid; the memories need no clearing.
`default_nettype none

module cursor_line_editor #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1),
  parameter int IDX_W        = $clog2(BUFFER_DEPTH)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  cle_pkg::action_t in_action,
  input  wire [7:0]        in_key,
  input  wire [IDX_W-1:0]  in_index,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       out_read_char,
  output logic [CNT_W-1:0] out_text_length,
  output logic [CNT_W-1:0] out_cursor_position,
  output logic             out_dropped
);
  import cle_pkg::*;

  cle_cmd_t cmd;

  cle_ctrl u_cle_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cle_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CNT_W        (CNT_W),
    .IDX_W        (IDX_W)
  ) u_cle_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_index            (in_index),
    .out_read_char       (out_read_char),
    .out_text_length     (out_text_length),
    .out_cursor_position (out_cursor_position),
    .out_dropped         (out_dropped)
  );

endmodule

`default_nettype wire

/* hdl/cle_ctrl.sv */
// controller: two-state sequencer and output valid flag
// depends on cle_pkg
`default_nettype none

module cle_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  output cle_pkg::cle_cmd_t cmd
);
  import cle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the read data until the output register can take the result
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/cle_datapath.sv */
// datapath: both stack memories, stack counts and the output payload registers
// depends on cle_pkg; driven by cle_ctrl commands
`default_nettype none

module cle_datapath #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int CNT_W        = 11,
  parameter int IDX_W        = 10
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cle_pkg::cle_cmd_t  cmd,
  input  cle_pkg::action_t   in_action,
  input  wire [7:0]          in_key,
  input  wire [IDX_W-1:0]    in_index,
  output logic [7:0]         out_read_char,
  output logic [CNT_W-1:0]   out_text_length,
  output logic [CNT_W-1:0]   out_cursor_position,
  output logic               out_dropped
);
  import cle_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [7:0] left_mem  [BUFFER_DEPTH];
  logic [7:0] right_mem [BUFFER_DEPTH];

  logic [CNT_W-1:0] left_cnt_r, left_cnt_nxt;
  logic [CNT_W-1:0] right_cnt_r, right_cnt_nxt;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] idx_ext;

  action_t    act_r;
  logic [7:0] key_r;
  logic       sel_left_r, in_range_r;
  logic [7:0] lrd_r, rrd_r;

  logic [IDX_W-1:0] left_raddr, right_raddr;
  logic [CNT_W-1:0] right_pos;

  logic             left_we, right_we;
  logic [IDX_W-1:0] left_waddr, right_waddr;
  logic [7:0]       left_wdata, right_wdata;
  logic [7:0]       char_nxt;
  logic             drop_nxt;

  assign total   = left_cnt_r + right_cnt_r;
  assign idx_ext = CNT_W'(in_index);

  // read addresses: stack tops for cursor moves, text position for reads
  assign right_pos = total - ONE_C - idx_ext;
  always_comb begin
    left_raddr  = in_index;
    right_raddr = right_pos[IDX_W-1:0];
    if (in_action == ACT_KEY) begin
      left_raddr  = IDX_W'(left_cnt_r - ONE_C);
      right_raddr = IDX_W'(right_cnt_r - ONE_C);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r      <= in_action;
      key_r      <= in_key;
      sel_left_r <= idx_ext < left_cnt_r;
      in_range_r <= idx_ext < total;
      lrd_r      <= left_mem[left_raddr];
      rrd_r      <= right_mem[right_raddr];
    end
  end

  always_comb begin
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    left_we       = 1'b0;
    right_we      = 1'b0;
    left_waddr    = left_cnt_r[IDX_W-1:0];
    right_waddr   = right_cnt_r[IDX_W-1:0];
    left_wdata    = key_r;
    right_wdata   = lrd_r;
    char_nxt      = 8'd0;
    drop_nxt      = 1'b0;
    case (act_r)
      ACT_KEY: begin
        case (key_r)
          KEY_LEFT: begin
            if (left_cnt_r != '0) begin
              right_we      = 1'b1;
              left_cnt_nxt  = left_cnt_r - ONE_C;
              right_cnt_nxt = right_cnt_r + ONE_C;
            end
          end
          KEY_RIGHT: begin
            if (right_cnt_r != '0) begin
              left_we       = 1'b1;
              left_wdata    = rrd_r;
              left_cnt_nxt  = left_cnt_r + ONE_C;
              right_cnt_nxt = right_cnt_r - ONE_C;
            end
          end
          KEY_BACK: begin
            if (left_cnt_r != '0) begin
              left_cnt_nxt = left_cnt_r - ONE_C;
            end
          end
          default: begin
            if (total >= DEPTH_C) begin
              drop_nxt = 1'b1;
            end else begin
              left_we      = 1'b1;
              left_cnt_nxt = left_cnt_r + ONE_C;
            end
          end
        endcase
      end
      ACT_READ: begin
        if (sel_left_r) begin
          char_nxt = lrd_r;
        end else if (in_range_r) begin
          char_nxt = rrd_r;
        end
      end
      ACT_CLEAR: begin
        left_cnt_nxt  = '0;
        right_cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && left_we) begin
      left_mem[left_waddr] <= left_wdata;
    end
    if (cmd.finish && right_we) begin
      right_mem[right_waddr] <= right_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
    end else if (cmd.finish) begin
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_char       <= char_nxt;
      out_text_length     <= left_cnt_nxt + right_cnt_nxt;
      out_cursor_position <= left_cnt_nxt;
      out_dropped         <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/cle_checker.sv */
// port-level checks for cursor_line_editor, attached with a bind
// depends on cle_pkg and the cursor_line_editor port list
`default_nettype none

module cle_checker #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int CNT_W        = 11
) (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_stall,
  input wire             out_valid,
  input wire             out_stall,
  input wire [7:0]       out_read_char,
  input wire [CNT_W-1:0] out_text_length,
  input wire [CNT_W-1:0] out_cursor_position,
  input wire             out_dropped
);
  import cle_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_char)
      && $stable(out_text_length) && $stable(out_cursor_position) && $stable(out_dropped))
    else $error("stalled result changed");

  // cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_position <= out_text_length)
    else $error("cursor beyond text length");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_text_length <= DEPTH_C)
    else $error("text length above buffer depth");

  // a drop only happens against a full buffer
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_text_length == DEPTH_C && out_read_char == 8'd0)
    else $error("drop reported on a buffer that is not full");

  // one transaction at a time: input is stalled right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is in flight");

endmodule

bind cursor_line_editor cle_checker #(
  .BUFFER_DEPTH (BUFFER_DEPTH),
  .CNT_W        (CNT_W)
) u_cle_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_read_char       (out_read_char),
  .out_text_length     (out_text_length),
  .out_cursor_position (out_cursor_position),
  .out_dropped         (out_dropped)
);

`default_nettype wire
